>>> design/alas_pkg.sv
// Shared types and constants of the aging Life automaton step core.
// Used by alas_ctrl, alas_datapath and aging_life_automaton_step_core.
package alas_pkg;

   localparam int DEFAULT_MAX_ROWS = 64;
   localparam int DEFAULT_MAX_COLS = 64;
   localparam int LIMIT_W          = 11;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_STEP  = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   localparam logic [3:0] CSR_GRID_ROWS     = 4'd0;
   localparam logic [3:0] CSR_GRID_COLS     = 4'd1;
   localparam logic [3:0] CSR_BOUNDED_EDGES = 4'd2;
   localparam logic [3:0] CSR_STALL_DETECT  = 4'd3;

   localparam logic [7:0] AGE_NEWBORN = 8'd255;
   localparam logic [3:0] K_CENTER    = 4'd4;
   localparam logic [3:0] K_LAST      = 4'd8;

   typedef struct packed {
      logic [1:0] opcode;
      logic [5:0] row;
      logic [5:0] col;
      logic [7:0] cell_value;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_value;
      logic [12:0] alive_count;
      logic        stalled;
   } rsp_type;

   typedef struct packed {
      logic latch_req;
      logic do_write;
      logic do_read;
      logic capture_read;
      logic init_step;
      logic step_run;
      logic clear_start;
      logic clear_run;
   } cmd_type;

   typedef struct packed {
      logic step_done;
      logic clear_done;
   } status_type;

endpackage

>>> design/aging_life_automaton_step_core.sv
// Top level of the aging Life automaton step core: configuration registers,
// controller and datapath. Depends on alas_pkg, alas_ctrl and alas_datapath.
//
// A command is taken when start is high while busy is low, and the block
// answers every command with exactly one result, shown on rsp_data for a single
// cycle while rsp_valid is high; the receiver cannot stall it, so it must take
// each result in that cycle. A write passes through the states S_WRITE and
// S_RESP, a read through S_READ, S_READ_WAIT and S_RESP: memory access, then
// the result state. Clear sweeps every entry of frame 0 of the cell memory one
// entry per cycle. Step reads the nine cells around each cell of the grid in
// use through the single memory read port; the next generation is written
// into the other frame in the same sweep and the frames swap at its end.
// Configuration transfers are always ready and must only be issued while the
// block is idle.
module aging_life_automaton_step_core #(
   parameter int MAX_ROWS = alas_pkg::DEFAULT_MAX_ROWS,
   parameter int MAX_COLS = alas_pkg::DEFAULT_MAX_COLS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  alas_pkg::req_type req_data,
   output logic              rsp_valid,
   output alas_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [3:0]        csr_index,
   input  logic [7:0]        csr_data
);

   alas_pkg::cmd_type    cmd;
   alas_pkg::status_type status;

   logic [6:0] grid_rows_ff;
   logic [6:0] grid_cols_ff;
   logic       bounded_edges_ff;
   logic       stall_detect_ff;

   // The configuration port never pushes back.
   assign csr_ready = 1'b1;

   // Writes to indexes beyond the register list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff     <= 7'd64;
         grid_cols_ff     <= 7'd64;
         bounded_edges_ff <= 1'b0;
         stall_detect_ff  <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            alas_pkg::CSR_GRID_ROWS:     grid_rows_ff     <= csr_data[6:0];
            alas_pkg::CSR_GRID_COLS:     grid_cols_ff     <= csr_data[6:0];
            alas_pkg::CSR_BOUNDED_EDGES: bounded_edges_ff <= csr_data[0];
            alas_pkg::CSR_STALL_DETECT:  stall_detect_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   alas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .opcode    (req_data.opcode),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   alas_datapath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_data      (req_data),
      .grid_rows     (grid_rows_ff),
      .grid_cols     (grid_cols_ff),
      .bounded_edges (bounded_edges_ff),
      .stall_detect  (stall_detect_ff),
      .status        (status),
      .rsp_data      (rsp_data)
   );

   // An accepted command keeps the block busy on the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("command accepted but block not busy");

   // A result strobe lasts exactly one cycle and only ends a command.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   // The stall flag is sticky until reset.
   a_stall_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_data.stalled |=> rsp_data.stalled)
      else $error("stall flag cleared without reset");

endmodule

>>> design/alas_ctrl.sv
// Controller state machine of the aging Life automaton step core.
// Depends on alas_pkg for the opcode codes and the command and status structs.
module alas_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [1:0]           opcode,
   input  alas_pkg::status_type status,
   output alas_pkg::cmd_type    cmd,
   output logic                 busy,
   output logic                 rsp_valid
);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_WRITE     = 3'd1;
   localparam logic [2:0] S_READ      = 3'd2;
   localparam logic [2:0] S_READ_WAIT = 3'd3;
   localparam logic [2:0] S_STEP      = 3'd4;
   localparam logic [2:0] S_CLEAR     = 3'd5;
   localparam logic [2:0] S_RESP      = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch_req = 1'b1;
               case (opcode)
                  alas_pkg::OP_WRITE: state_in = S_WRITE;
                  alas_pkg::OP_READ:  state_in = S_READ;
                  alas_pkg::OP_STEP: begin
                     cmd.init_step = 1'b1;
                     state_in      = S_STEP;
                  end
                  default: begin
                     cmd.clear_start = 1'b1;
                     state_in        = S_CLEAR;
                  end
               endcase
            end
         end
         S_WRITE: begin
            cmd.do_write = 1'b1;
            state_in     = S_RESP;
         end
         S_READ: begin
            cmd.do_read = 1'b1;
            state_in    = S_READ_WAIT;
         end
         S_READ_WAIT: begin
            cmd.capture_read = 1'b1;
            state_in         = S_RESP;
         end
         S_STEP: begin
            cmd.step_run = 1'b1;
            if (status.step_done) state_in = S_RESP;
         end
         S_CLEAR: begin
            cmd.clear_run = 1'b1;
            if (status.clear_done) state_in = S_RESP;
         end
         S_RESP:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

endmodule

>>> design/alas_datapath.sv
// Datapath of the aging Life automaton step core: frame memory, cell sweep,
// neighbor count, age rule and result registers. Depends on alas_pkg.
module alas_datapath #(
   parameter int MAX_ROWS = alas_pkg::DEFAULT_MAX_ROWS,
   parameter int MAX_COLS = alas_pkg::DEFAULT_MAX_COLS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  alas_pkg::cmd_type    cmd,
   input  alas_pkg::req_type    req_data,
   input  logic [6:0]           grid_rows,
   input  logic [6:0]           grid_cols,
   input  logic                 bounded_edges,
   input  logic                 stall_detect,
   output alas_pkg::status_type status,
   output alas_pkg::rsp_type    rsp_data
);

   localparam int LW  = alas_pkg::LIMIT_W;
   localparam int RW  = $clog2(MAX_ROWS);
   localparam int CW  = $clog2(MAX_COLS);
   localparam int ERW = RW + 1;
   localparam int ECW = CW + 1;
   localparam int AW  = 1 + RW + CW;

   logic [7:0] mem [2**AW];
   logic [7:0] rdata_ff;

   alas_pkg::req_type req_ff;
   logic              inside_ff;
   logic [7:0]        rd_value_ff;
   logic              cur_ff;
   logic [12:0]       live_total_ff;
   logic              stall_ff;

   logic [RW-1:0]     r_ff;
   logic [CW-1:0]     c_ff;
   logic [3:0]        k_ff;
   logic              run_ff;
   logic              a_valid_ff;
   logic              a_skip_ff;
   logic              a_last_ff;
   logic [3:0]        a_k_ff;
   logic [RW-1:0]     a_r_ff;
   logic [CW-1:0]     a_c_ff;
   logic [3:0]        n_ff;
   logic [7:0]        center_ff;
   logic [12:0]       live_cnt_ff;
   logic              newborn_ff;
   logic [RW+CW-1:0]  clr_ff;

   logic [LW-1:0]  gr_w, gc_w;
   logic [ERW-1:0] eff_rows;
   logic [ECW-1:0] eff_cols;
   logic           req_inside;
   logic           last_col, last_row, issue;
   logic [ERW-1:0] r_inc;
   logic [ECW-1:0] c_inc;
   logic [RW-1:0]  row_up, row_dn, nb_r;
   logic [CW-1:0]  col_lf, col_rt, nb_c;
   logic           up_out, dn_out, lf_out, rt_out, nb_skip;
   logic [AW-1:0]  raddr;
   logic [AW-1:0]  waddr;
   logic [7:0]     wdata;
   logic           we;
   logic           hit;
   logic [3:0]     n_total;
   logic [7:0]     nv;
   logic           cell_end;

   // Effective grid size: zero acts as one, anything above the maximum clamps.
   always_comb begin
      gr_w = LW'(grid_rows);
      gc_w = LW'(grid_cols);
      if (gr_w == '0)                  eff_rows = ERW'(1);
      else if (gr_w > LW'(MAX_ROWS))   eff_rows = ERW'(MAX_ROWS);
      else                             eff_rows = ERW'(gr_w);
      if (gc_w == '0)                  eff_cols = ECW'(1);
      else if (gc_w > LW'(MAX_COLS))   eff_cols = ECW'(MAX_COLS);
      else                             eff_cols = ECW'(gc_w);
      req_inside = (LW'(req_data.row) < LW'(eff_rows)) &&
                   (LW'(req_data.col) < LW'(eff_cols));
   end

   // Neighbor position of the current sweep point, with wrap or edge flags.
   always_comb begin
      r_inc  = {1'b0, r_ff} + ERW'(1);
      c_inc  = {1'b0, c_ff} + ECW'(1);
      up_out = (r_ff == '0);
      dn_out = (r_inc >= eff_rows);
      lf_out = (c_ff == '0);
      rt_out = (c_inc >= eff_cols);
      row_up = up_out ? RW'(eff_rows - ERW'(1)) : r_ff - RW'(1);
      row_dn = dn_out ? '0 : RW'(r_inc);
      col_lf = lf_out ? CW'(eff_cols - ECW'(1)) : c_ff - CW'(1);
      col_rt = rt_out ? '0 : CW'(c_inc);
      nb_skip = 1'b0;
      if (k_ff < 4'd3) begin
         nb_r    = row_up;
         nb_skip = up_out;
      end else if (k_ff < 4'd6) begin
         nb_r = r_ff;
      end else begin
         nb_r    = row_dn;
         nb_skip = dn_out;
      end
      case (k_ff)
         4'd0, 4'd3, 4'd6: begin
            nb_c    = col_lf;
            nb_skip = nb_skip | lf_out;
         end
         4'd2, 4'd5, 4'd8: begin
            nb_c    = col_rt;
            nb_skip = nb_skip | rt_out;
         end
         default: nb_c = c_ff;
      endcase
      nb_skip  = nb_skip & bounded_edges;
      last_col = ({1'b0, c_ff} == eff_cols - ECW'(1));
      last_row = ({1'b0, r_ff} == eff_rows - ERW'(1));
      issue    = cmd.step_run && run_ff;
   end

   // Age rule applied when the last neighbor of a cell returns.
   always_comb begin
      hit      = a_valid_ff && !a_skip_ff && (a_k_ff != alas_pkg::K_CENTER) &&
                 (rdata_ff != 8'd0);
      n_total  = n_ff + {3'd0, hit};
      cell_end = a_valid_ff && (a_k_ff == alas_pkg::K_LAST);
      if (n_total < 4'd2 || n_total > 4'd3) nv = 8'd0;
      else if (center_ff == 8'd0)           nv = (n_total == 4'd3) ?
                                                 alas_pkg::AGE_NEWBORN : 8'd0;
      else if (center_ff == 8'd1)           nv = 8'd1;
      else                                  nv = center_ff - 8'd1;
   end

   always_comb begin
      we    = 1'b0;
      waddr = {cur_ff, RW'(req_ff.row), CW'(req_ff.col)};
      wdata = req_ff.cell_value;
      if (cell_end) begin
         we    = 1'b1;
         waddr = {~cur_ff, a_r_ff, a_c_ff};
         wdata = nv;
      end else if (cmd.clear_run) begin
         we    = 1'b1;
         waddr = {1'b0, clr_ff};
         wdata = 8'd0;
      end else if (cmd.do_write) begin
         we = inside_ff;
      end
      raddr = issue ? {cur_ff, nb_r, nb_c} : {cur_ff, RW'(req_ff.row), CW'(req_ff.col)};
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         req_ff    <= req_data;
         inside_ff <= req_inside;
      end
      if (cmd.init_step) begin
         r_ff <= '0;
         c_ff <= '0;
         k_ff <= '0;
      end else if (issue) begin
         a_k_ff    <= k_ff;
         a_skip_ff <= nb_skip;
         a_r_ff    <= r_ff;
         a_c_ff    <= c_ff;
         a_last_ff <= (k_ff == alas_pkg::K_LAST) && last_col && last_row;
         if (k_ff == alas_pkg::K_LAST) begin
            k_ff <= '0;
            if (last_col) begin
               c_ff <= '0;
               if (!last_row) r_ff <= r_ff + RW'(1);
            end else begin
               c_ff <= c_ff + CW'(1);
            end
         end else begin
            k_ff <= k_ff + 4'd1;
         end
      end
      if (a_valid_ff && a_k_ff == alas_pkg::K_CENTER) center_ff <= rdata_ff;
      if (cmd.init_step || cell_end) n_ff <= 4'd0;
      else if (a_valid_ff)           n_ff <= n_total;
      if (cmd.clear_start)    clr_ff <= '0;
      else if (cmd.clear_run) clr_ff <= clr_ff + (RW+CW)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff        <= 1'b0;
         a_valid_ff    <= 1'b0;
         cur_ff        <= 1'b0;
         live_total_ff <= '0;
         live_cnt_ff   <= '0;
         newborn_ff    <= 1'b0;
         stall_ff      <= 1'b0;
         rd_value_ff   <= '0;
      end else begin
         a_valid_ff <= issue;
         if (cmd.latch_req) rd_value_ff <= 8'd0;
         if (cmd.capture_read) rd_value_ff <= inside_ff ? rdata_ff : 8'd0;
         if (cmd.init_step) begin
            run_ff      <= 1'b1;
            live_cnt_ff <= '0;
            newborn_ff  <= 1'b0;
         end else if (issue && k_ff == alas_pkg::K_LAST && last_col && last_row) begin
            run_ff <= 1'b0;
         end
         if (cell_end) begin
            live_cnt_ff <= live_cnt_ff + 13'(nv != 8'd0);
            newborn_ff  <= newborn_ff | (nv == alas_pkg::AGE_NEWBORN);
            if (a_last_ff) begin
               cur_ff        <= ~cur_ff;
               live_total_ff <= live_cnt_ff + 13'(nv != 8'd0);
               if (stall_detect && !(newborn_ff || nv == alas_pkg::AGE_NEWBORN))
                  stall_ff <= 1'b1;
            end
         end
         if (cmd.clear_start) cur_ff <= 1'b0;
      end
   end

   assign status.step_done  = cell_end && a_last_ff;
   assign status.clear_done = cmd.clear_run && (clr_ff == '1);

   assign rsp_data.read_value  = rd_value_ff;
   assign rsp_data.alive_count = live_total_ff;
   assign rsp_data.stalled     = stall_ff;

endmodule
